// ----- rtl/mch_pkg.sv -----
package mch_pkg;

    localparam int REG_OFFSET = 0;
    localparam int REG_ROW0   = 1;
    localparam int REG_ROW1   = 2;
    localparam int REG_ROW2   = 3;
    localparam int REG_CALIB  = 4;

    localparam int ANG_W = 28;
    localparam int HEADING_FULL = 5760;
    localparam int HEADING_HALF = 2880;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        logic               valid;
        logic               last;
    } vec_t;

    function automatic logic signed [ANG_W-1:0] atan_deg(input int i);
        logic signed [ANG_W-1:0] r;
        unique case (i)
            0: r = 28'sd2949120;   1: r = 28'sd1740967;  2: r = 28'sd919879;
            3: r = 28'sd466945;    4: r = 28'sd234379;   5: r = 28'sd117304;
            6: r = 28'sd58666;     7: r = 28'sd29335;    8: r = 28'sd14668;
            9: r = 28'sd7334;      10: r = 28'sd3667;    11: r = 28'sd1833;
            12: r = 28'sd917;      13: r = 28'sd458;     14: r = 28'sd229;
            15: r = 28'sd115;      16: r = 28'sd57;      17: r = 28'sd29;
            18: r = 28'sd14;       19: r = 28'sd7;       20: r = 28'sd4;
            21: r = 28'sd2;        22: r = 28'sd1;
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [39:0] v);
        if (v > 40'sd32767) return 16'sh7fff;
        if (v < -40'sd32768) return 16'sh8000;
        return v[15:0];
    endfunction

endpackage

// ----- rtl/mch_front.sv -----
module mch_front import mch_pkg::*; #(
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic signed [15:0]  raw_x,
    input  logic signed [15:0]  raw_y,
    input  logic signed [15:0]  raw_z,
    input  logic                block_end,
    input  logic [47:0]         offset_xyz,
    input  logic [47:0]         matrix_row0,
    input  logic [47:0]         matrix_row1,
    input  logic [47:0]         matrix_row2,
    input  logic                calib,
    output logic                out_valid,
    input  logic                out_ready,
    output vec_t                out_vec
);
    // stage 1: scale and offset, stage 2: products, stage 3: sums and saturation
    localparam int NW = SAMPLE_WIDTH + 7;
    localparam int VW = ((SAMPLE_WIDTH > 16) ? SAMPLE_WIDTH : 16) + 4;
    localparam int PVW = VW + 16;
    localparam int AW = VW + 18;
    localparam logic [31:0] RECIP10 = 32'd429496730;

    logic [2:0] vld_reg;
    logic       adv1, adv2, adv3;

    assign adv3 = !vld_reg[2] || out_ready;
    assign adv2 = !vld_reg[1] || adv3;
    assign adv1 = !vld_reg[0] || adv2;
    assign in_ready = adv1;
    assign out_valid = vld_reg[2];

    logic [31:0]                    ext [3];
    logic signed [SAMPLE_WIDTH-1:0] raw [3];
    assign ext[0] = {16'd0, raw_x};
    assign ext[1] = {16'd0, raw_y};
    assign ext[2] = {16'd0, raw_z};
    assign raw[0] = ext[0][SAMPLE_WIDTH-1:0];
    assign raw[1] = ext[1][SAMPLE_WIDTH-1:0];
    assign raw[2] = ext[2][SAMPLE_WIDTH-1:0];

    logic signed [VW-1:0] v_reg [3];
    logic signed [VW-1:0] v_next [3];
    logic                 cal1_reg, last1_reg;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            logic signed [NW-1:0] n;
            logic [NW-1:0]        m;
            logic [NW+31:0]       prod;
            logic [NW-1:0]        q;
            logic signed [NW-1:0] quot;
            n = NW'(raw[k]) * NW'(48) + NW'(5);
            // floor division by 10 via reciprocal multiply, negative side mirrored by inversion
            m = n[NW-1] ? ~n : n;
            prod = (NW+32)'(m) * (NW+32)'(RECIP10);
            q = prod[NW+31:32];
            quot = n[NW-1] ? ~q : q;
            v_next[k] = VW'(quot) + VW'($signed(offset_xyz[16*k +: 16]));
        end
    end

    logic signed [PVW-1:0] p_reg [9];
    logic                  cal2_reg, last2_reg;
    logic [47:0]           rows [3];
    assign rows[0] = matrix_row0;
    assign rows[1] = matrix_row1;
    assign rows[2] = matrix_row2;

    logic signed [AW-1:0] acc [3];
    vec_t v3_next;
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            acc[r] = AW'(p_reg[3*r]) + AW'(p_reg[3*r+1])
                   + AW'(p_reg[3*r+2]) + AW'(8192);
        end
        v3_next.x = sat16(40'(acc[0] >>> 14));
        v3_next.y = sat16(40'(acc[1] >>> 14));
        v3_next.z = sat16(40'(acc[2] >>> 14));
        v3_next.valid = cal2_reg;
        v3_next.last = last2_reg;
        if (!cal2_reg) begin
            v3_next.x = '0;
            v3_next.y = '0;
            v3_next.z = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (adv1) vld_reg[0] <= in_valid;
            if (adv2) vld_reg[1] <= vld_reg[0];
            if (adv3) vld_reg[2] <= vld_reg[1];
        end
        if (adv1) begin
            for (int k = 0; k < 3; k++) v_reg[k] <= v_next[k];
            cal1_reg <= calib;
            last1_reg <= block_end;
        end
        if (adv2) begin
            for (int r = 0; r < 3; r++)
                for (int c = 0; c < 3; c++)
                    p_reg[3*r+c] <= PVW'($signed(rows[r][16*c +: 16]))
                                  * PVW'(v_reg[c]);
            cal2_reg <= cal1_reg;
            last2_reg <= last1_reg;
        end
        if (adv3) out_vec <= v3_next;
    end
endmodule

// ----- rtl/mch_fifo.sv -----
module mch_fifo import mch_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic in_valid,
    output logic in_ready,
    input  vec_t in_vec,
    output logic out_valid,
    input  logic out_ready,
    output vec_t out_vec
);
    vec_t       mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       wr, rd;

    assign in_ready = cnt_reg != 2'd2;
    assign out_valid = cnt_reg != 2'd0;
    assign out_vec = mem_reg[rp_reg];
    assign wr = in_valid && in_ready;
    assign rd = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= '0;
        end else begin
            if (wr) wp_reg <= !wp_reg;
            if (rd) rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + 2'(wr) - 2'(rd);
        end
        if (wr) mem_reg[wp_reg] <= in_vec;
    end
endmodule

// ----- rtl/mch_cordic.sv -----
module mch_cordic import mch_pkg::*; #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  vec_t               in_vec,
    output logic               out_valid,
    input  logic               out_ready,
    output vec_t               out_vec,
    output logic [12:0]        out_heading
);
    localparam int N = CORDIC_STAGES;
    localparam int CW = 28;

    logic [N:0]              vld_reg;
    logic [N:0]              adv;
    logic signed [CW-1:0]    x_reg [N+1];
    logic signed [CW-1:0]    y_reg [N+1];
    logic signed [ANG_W-1:0] z_reg [N+1];
    logic [N:0]              zero_reg;
    vec_t                    v_reg [N+1];

    always_comb begin
        adv[N] = !vld_reg[N] || out_ready;
        for (int i = N - 1; i >= 0; i--) adv[i] = !vld_reg[i] || adv[i+1];
    end
    assign in_ready = adv[0];
    assign out_valid = vld_reg[N];

    logic signed [CW-1:0]    a0, b0;
    logic signed [CW-1:0]    x0, y0;
    logic signed [ANG_W-1:0] z0;
    always_comb begin
        a0 = -(CW'(in_vec.x)) <<< 8;
        b0 = CW'(in_vec.y) <<< 8;
        x0 = b0;
        y0 = a0;
        z0 = '0;
        if (b0 < 0) begin
            z0 = (a0 >= 0) ? ANG_W'(180 * 65536) : -ANG_W'(180 * 65536);
            x0 = -b0;
            y0 = -a0;
        end
    end

    logic signed [ANG_W-1:0] hsum;
    logic signed [ANG_W-1:0] hraw;
    logic [12:0]             hd;
    always_comb begin
        hsum = (z_reg[N] + ANG_W'(2048)) >>> 12;
        hraw = hsum + ANG_W'(HEADING_HALF);
        if (hraw >= ANG_W'(HEADING_FULL)) hraw = hraw - ANG_W'(HEADING_FULL);
        else if (hraw < 0) hraw = hraw + ANG_W'(HEADING_FULL);
        hd = hraw[12:0];
        if (zero_reg[N]) hd = 13'(HEADING_HALF);
        if (!v_reg[N].valid) hd = '0;
    end
    assign out_vec = v_reg[N];
    assign out_heading = hd;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (adv[0]) vld_reg[0] <= in_valid;
            for (int i = 1; i <= N; i++) if (adv[i]) vld_reg[i] <= vld_reg[i-1];
        end
        if (adv[0]) begin
            x_reg[0] <= x0;
            y_reg[0] <= y0;
            z_reg[0] <= z0;
            zero_reg[0] <= (in_vec.x == 0) && (in_vec.y == 0);
            v_reg[0] <= in_vec;
        end
        for (int i = 1; i <= N; i++) begin
            if (adv[i]) begin
                if (y_reg[i-1] >= 0) begin
                    x_reg[i] <= x_reg[i-1] + (y_reg[i-1] >>> (i-1));
                    y_reg[i] <= y_reg[i-1] - (x_reg[i-1] >>> (i-1));
                    z_reg[i] <= z_reg[i-1] + atan_deg(i-1);
                end else begin
                    x_reg[i] <= x_reg[i-1] - (y_reg[i-1] >>> (i-1));
                    y_reg[i] <= y_reg[i-1] + (x_reg[i-1] >>> (i-1));
                    z_reg[i] <= z_reg[i-1] - atan_deg(i-1);
                end
                zero_reg[i] <= zero_reg[i-1];
                v_reg[i] <= v_reg[i-1];
            end
        end
    end
endmodule

// ----- rtl/magnetometer_correct_heading.sv -----
// the path holds 3 correction stages, the 2-entry queue and CORDIC_STAGES + 1 CORDIC stages
// throughput: one item per cycle, stalls run back from the output, the queue decouples the halves
// reset: synchronous active-low aresetn empties the pipeline and restores calibration
// registers to zero offset, identity matrix and calibration not loaded
module magnetometer_correct_heading import mch_pkg::*; #(
    parameter int SAMPLE_WIDTH  = 16,
    parameter int CORDIC_STAGES = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [47:0]        cfg_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [15:0] s_raw_x,
    input  logic signed [15:0] s_raw_y,
    input  logic signed [15:0] s_raw_z,
    input  logic               s_block_end,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [15:0] m_corrected_x,
    output logic signed [15:0] m_corrected_y,
    output logic signed [15:0] m_corrected_z,
    output logic [12:0]        m_heading,
    output logic               m_result_valid,
    output logic               m_block_end_out
);
    logic [47:0] offset_reg, row0_reg, row1_reg, row2_reg;
    logic        calib_reg;

    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_reg <= '0;
            row0_reg <= 48'd16384;
            row1_reg <= 48'd16384 << 16;
            row2_reg <= 48'd16384 << 32;
            calib_reg <= 1'b0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                3'(REG_OFFSET): offset_reg <= cfg_data;
                3'(REG_ROW0):   row0_reg <= cfg_data;
                3'(REG_ROW1):   row1_reg <= cfg_data;
                3'(REG_ROW2):   row2_reg <= cfg_data;
                3'(REG_CALIB):  calib_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    logic f_valid, f_ready, q_valid, q_ready;
    vec_t f_vec, q_vec, o_vec;

    mch_front #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_front (
        .aclk, .aresetn,
        .in_valid(s_valid), .in_ready(s_ready),
        .raw_x(s_raw_x), .raw_y(s_raw_y), .raw_z(s_raw_z), .block_end(s_block_end),
        .offset_xyz(offset_reg), .matrix_row0(row0_reg), .matrix_row1(row1_reg),
        .matrix_row2(row2_reg), .calib(calib_reg),
        .out_valid(f_valid), .out_ready(f_ready), .out_vec(f_vec)
    );

    mch_fifo u_fifo (
        .aclk, .aresetn,
        .in_valid(f_valid), .in_ready(f_ready), .in_vec(f_vec),
        .out_valid(q_valid), .out_ready(q_ready), .out_vec(q_vec)
    );

    mch_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_cordic (
        .aclk, .aresetn,
        .in_valid(q_valid), .in_ready(q_ready), .in_vec(q_vec),
        .out_valid(m_valid), .out_ready(m_ready), .out_vec(o_vec),
        .out_heading(m_heading)
    );

    assign m_corrected_x = o_vec.x;
    assign m_corrected_y = o_vec.y;
    assign m_corrected_z = o_vec.z;
    assign m_result_valid = o_vec.valid;
    assign m_block_end_out = o_vec.last;
endmodule

// ----- bench/magnetometer_correct_heading_test.sv -----
module magnetometer_correct_heading_test;
    import mch_pkg::*;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [2:0]         cfg_index = '0;
    logic [47:0]        cfg_data = '0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic signed [15:0] s_raw_x = '0;
    logic signed [15:0] s_raw_y = '0;
    logic signed [15:0] s_raw_z = '0;
    logic               s_block_end = 1'b0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic signed [15:0] m_corrected_x;
    logic signed [15:0] m_corrected_y;
    logic signed [15:0] m_corrected_z;
    logic [12:0]        m_heading;
    logic               m_result_valid;
    logic               m_block_end_out;

    typedef struct {
        logic signed [15:0] cx;
        logic signed [15:0] cy;
        logic signed [15:0] cz;
        logic [12:0]        hdg;
        logic               rv;
        logic               be;
    } sample_result_t;

    sample_result_t expected_results[$];

    logic [47:0] cal_offset;
    logic [47:0] cal_row[3];
    logic        cal_loaded;

    int items_sent = 0;
    int results_seen = 0;
    int mismatches = 0;
    int rx_wait = 0;
    bit hold_on = 1'b0;
    bit rx_stall_on = 1'b1;
    event hold_start;

    always #1 aclk = ~aclk;

    magnetometer_correct_heading dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_raw_x(s_raw_x), .s_raw_y(s_raw_y), .s_raw_z(s_raw_z),
        .s_block_end(s_block_end),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_corrected_x(m_corrected_x), .m_corrected_y(m_corrected_y),
        .m_corrected_z(m_corrected_z), .m_heading(m_heading),
        .m_result_valid(m_result_valid), .m_block_end_out(m_block_end_out)
    );

    function automatic longint floor_shr(longint v, int s);
        if (v >= 0) return v >>> s;
        return -(((-v) - 1) >>> s) - 1;
    endfunction

    function automatic longint clamp16(longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    function automatic longint field16(logic [47:0] w, int k);
        logic signed [15:0] f;
        f = w[16*k +: 16];
        return longint'(f);
    endfunction

    function automatic longint compass_heading(longint a, longint b);
        longint x, y, z, t, h;
        z = 0;
        if (a == 0 && b == 0) return HEADING_HALF;
        x = b * 256;
        y = a * 256;
        if (x < 0) begin
            z = (y >= 0) ? 180 * 65536 : -180 * 65536;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < 16; i++) begin
            if (y >= 0) begin
                t = x + floor_shr(y, i);
                y = y - floor_shr(x, i);
                x = t;
                z += atan_deg(i);
            end else begin
                t = x - floor_shr(y, i);
                y = y + floor_shr(x, i);
                x = t;
                z -= atan_deg(i);
            end
        end
        h = floor_shr(z + 2048, 12) + HEADING_HALF;
        while (h >= HEADING_FULL) h -= HEADING_FULL;
        while (h < 0) h += HEADING_FULL;
        return h;
    endfunction

    function automatic sample_result_t correct_sample(logic signed [15:0] rx,
            logic signed [15:0] ry, logic signed [15:0] rz, logic blk);
        sample_result_t r;
        longint v[3], c[3], raw, n, acc;
        r.be = blk;
        if (!cal_loaded) begin
            r.cx = '0; r.cy = '0; r.cz = '0; r.hdg = '0; r.rv = 1'b0;
            return r;
        end
        for (int k = 0; k < 3; k++) begin
            raw = (k == 0) ? rx : (k == 1) ? ry : rz;
            n = raw * 48 + 5;
            v[k] = ((n >= 0) ? n / 10 : -(((-n) + 9) / 10)) + field16(cal_offset, k);
        end
        for (int j = 0; j < 3; j++) begin
            acc = field16(cal_row[j], 0) * v[0] + field16(cal_row[j], 1) * v[1]
                + field16(cal_row[j], 2) * v[2];
            c[j] = clamp16(floor_shr(acc + 8192, 14));
        end
        r.cx = 16'(c[0]); r.cy = 16'(c[1]); r.cz = 16'(c[2]);
        r.hdg = 13'(compass_heading(-c[0], c[1]));
        r.rv = 1'b1;
        return r;
    endfunction

    // long hold-off of the receiver, counted in cycles
    initial forever begin
        @(hold_start);
        hold_on <= 1'b1;
        repeat (80) @(posedge aclk);
        hold_on <= 1'b0;
    end

    // receiver: draws a wait after each item
    always @(posedge aclk) begin
        int w;
        if (!aresetn) begin
            m_ready <= 1'b0;
            rx_wait <= 0;
        end else if (hold_on) begin
            m_ready <= 1'b0;
        end else if (m_valid && m_ready) begin
            w = (rx_stall_on && $urandom_range(0, 3) == 0) ? int'($urandom_range(0, 8)) : 0;
            rx_wait <= w;
            m_ready <= (w == 0);
        end else if (rx_wait > 0) begin
            rx_wait <= rx_wait - 1;
            m_ready <= (rx_wait == 1);
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        sample_result_t e;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result at %0t", $realtime);
            end else begin
                e = expected_results.pop_front();
                if (m_corrected_x !== e.cx || m_corrected_y !== e.cy ||
                    m_corrected_z !== e.cz || m_heading !== e.hdg ||
                    m_result_valid !== e.rv || m_block_end_out !== e.be) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp %0d %0d %0d h%0d v%0d e%0d got %0d %0d %0d h%0d v%0d e%0d",
                            e.cx, e.cy, e.cz, e.hdg, e.rv, e.be, m_corrected_x,
                            m_corrected_y, m_corrected_z, m_heading, m_result_valid,
                            m_block_end_out);
                end
            end
        end
    end

    task automatic send_sample(logic signed [15:0] rx, logic signed [15:0] ry,
            logic signed [15:0] rz, logic blk, int gap);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_raw_x <= rx; s_raw_y <= ry; s_raw_z <= rz; s_block_end <= blk;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        expected_results.push_back(correct_sample(rx, ry, rz, blk));
        items_sent++;
    endtask

    task automatic drain_pipeline;
        s_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [47:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            REG_OFFSET: cal_offset = val;
            REG_ROW0:   cal_row[0] = val;
            REG_ROW1:   cal_row[1] = val;
            REG_ROW2:   cal_row[2] = val;
            REG_CALIB:  cal_loaded = val[0];
            default: ;
        endcase
    endtask

    task automatic load_calibration(logic [47:0] off, logic [47:0] r0, logic [47:0] r1,
            logic [47:0] r2, logic ld);
        drain_pipeline();
        write_reg(REG_OFFSET, off);
        write_reg(REG_ROW0, r0);
        write_reg(REG_ROW1, r1);
        write_reg(REG_ROW2, r2);
        write_reg(REG_CALIB, {47'd0, ld});
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [15:0] rand_coef();
        case ($urandom_range(0, 3))
            0: return 16'($urandom_range(14000, 18000));
            1: return 16'(-$urandom_range(0, 3000));
            2: return 16'($urandom_range(0, 3000));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic signed [15:0] rand_raw();
        case ($urandom_range(0, 5))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return 16'($urandom_range(0, 40)) - 16'sd20;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic test_uncalibrated;
        send_sample(16'sh7fff, 16'sh8000, 16'sd1, 1'b1, 0);
        send_sample(16'sh1234, -16'sd5, 16'sd0, 1'b0, 0);
        send_sample(16'sh8000, 16'sh7fff, 16'sh8000, 1'b1, 2);
    endtask

    task automatic test_directed_identity;
        load_calibration(48'd0, 48'd16384, 48'd16384 << 16, 48'd16384 << 32, 1'b1);
        send_sample(16'sd0, 16'sd0, 16'sd0, 1'b0, 0);       // zero vector
        send_sample(16'sd0, 16'sd10, 16'sd0, 1'b1, 0);
        send_sample(16'sd0, -16'sd10, 16'sd0, 1'b0, 1);     // wraps to 0
        send_sample(16'sd10, 16'sd0, 16'sd0, 1'b0, 0);
        send_sample(-16'sd10, 16'sd0, 16'sd0, 1'b0, 0);
        send_sample(16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b1, 0);
        send_sample(16'sh8000, 16'sh8000, 16'sh8000, 1'b0, 0);
        send_sample(16'sh7fff, 16'sh8000, 16'sd1, 1'b0, 3);
        send_sample(-16'sd1, 16'sd1, -16'sd1, 1'b1, 0);
        load_calibration(48'h8000_7fff_8000, 48'h8000_8000_8000,
                         48'h7fff_7fff_7fff, 48'h0000_8000_7fff, 1'b1);
        send_sample(16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b0, 0);
        send_sample(16'sh8000, 16'sh8000, 16'sh8000, 1'b1, 0);
        send_sample(16'sd0, 16'sd0, 16'sd0, 1'b0, 0);
        send_sample(16'sh5555, 16'shaaaa, 16'sh00ff, 1'b0, 0);
        load_calibration(48'hffff_ffff_ffff, 48'hffff_ffff_ffff,
                         48'hffff_ffff_ffff, 48'hffff_ffff_ffff, 1'b1);
        send_sample(16'shaaaa, 16'sh5555, 16'shff00, 1'b1, 0);
        drain_pipeline();
        write_reg(3'd7, 48'hffff_ffff_ffff);   // unknown index, ignored
        cfg_valid <= 1'b0;
        send_sample(16'sd100, -16'sd100, 16'sd0, 1'b0, 0);
    endtask

    task automatic test_random_phases;
        for (int ph = 0; ph < 10; ph++) begin
            load_calibration({rand_coef(), rand_coef(), rand_coef()},
                             {rand_coef(), rand_coef(), rand_coef()},
                             {rand_coef(), rand_coef(), rand_coef()},
                             {rand_coef(), rand_coef(), rand_coef()}, ph != 4);
            rx_stall_on = (ph % 3) != 2;
            for (int i = 0; i < 105; i++)
                send_sample(rand_raw(), rand_raw(), rand_raw(), 1'($urandom),
                    (ph % 3 == 1) ? 0 : (($urandom_range(0, 3) == 0) ? $urandom_range(0, 8) : 0));
        end
        rx_stall_on = 1'b1;
    endtask

    task automatic test_backpressure;
        drain_pipeline();   // sender waited for every result
        -> hold_start;
        for (int i = 0; i < 40; i++)
            send_sample(rand_raw(), rand_raw(), rand_raw(), 1'($urandom), 0);
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        cal_offset = '0;
        cal_row[0] = 48'd16384;
        cal_row[1] = 48'd16384 << 16;
        cal_row[2] = 48'd16384 << 32;
        cal_loaded = 1'b0;
        @(posedge aclk);
        test_uncalibrated();
        test_directed_identity();
        test_random_phases();
        test_backpressure();
        drain_pipeline();
        $display("covered %0d samples, %0d results, uncalibrated and saturating settings",
                 items_sent, results_seen);
        if (mismatches == 0) begin
            $display("magnetometer_correct_heading_test: PASS");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("magnetometer_correct_heading_test: FAIL");
        end
        $finish;
    end

    initial begin
        #200000;
        $display("timeout");
        $display("magnetometer_correct_heading_test: FAIL");
        $finish;
    end
endmodule

// ----- filelist.f -----
rtl/mch_pkg.sv
rtl/mch_front.sv
rtl/mch_fifo.sv
rtl/mch_cordic.sv
rtl/magnetometer_correct_heading.sv
bench/magnetometer_correct_heading_test.sv
